// File: src/lfsf_pkg.sv
// Shared constants and types for the largest free square finder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lfsf_pkg;

  localparam int LFSF_MAX_COLS = 1024;
  localparam int LFSF_MAX_ROWS = 1024;

  localparam int SCORE_W = 11;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam int OUT_ROW_W = 10;
  localparam int OUT_COL_W = 10;

  localparam int ROW_WIDTH_W = 11;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ROW_WIDTH = 1'b0;

  // Control flags of the item held in the scoring stage
  typedef struct packed {
    logic valid;
    logic cell_open;
    logic last_cell;
    logic end_row;
  } lfsf_s1_t;

endpackage
`default_nettype wire

// File: src/lfsf_if.sv
// Valid/ready channel interfaces for cell items and result items.
// Depends on lfsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lfsf_in_if;
  import lfsf_pkg::*;
  logic valid;
  logic ready;
  logic cell_open;
  logic last_cell;
  modport source (output valid, output cell_open, output last_cell, input ready);
  modport sink (input valid, input cell_open, input last_cell, output ready);
endinterface

interface lfsf_out_if;
  import lfsf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SCORE_W-1:0]   best_size;
  logic [OUT_ROW_W-1:0] best_row;
  logic [OUT_COL_W-1:0] best_col;
  modport source (output valid, output best_size, output best_row, output best_col,
                  input ready);
  modport sink (input valid, input best_size, input best_row, input best_col,
                output ready);
endinterface
`default_nettype wire

// File: src/lfsf_row_mem.sv
// Previous-row score buffer: one write and one registered read per cycle.
// A read of the entry written in the same cycle returns the new score.
// Depends on lfsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfsf_row_mem #(
  parameter int MAX_COLS = lfsf_pkg::LFSF_MAX_COLS
) (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [$clog2(MAX_COLS)-1:0]          wr_addr,
  input  wire  [lfsf_pkg::SCORE_W-1:0]         wr_data,
  input  wire                                  rd_en,
  input  wire  [$clog2(MAX_COLS)-1:0]          rd_addr,
  output logic [lfsf_pkg::SCORE_W-1:0]         rd_data
);
  import lfsf_pkg::*;

  logic [SCORE_W-1:0] mem [MAX_COLS];
  logic [SCORE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: src/lfsf_cfg_regs.sv
// APB-style register file holding the row width.
// Depends on lfsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfsf_cfg_regs (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [lfsf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [lfsf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lfsf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [lfsf_pkg::ROW_WIDTH_W-1:0]   row_width
);
  import lfsf_pkg::*;

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic                   reg_idx;
  logic                   wr_hit;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_ROW_WIDTH)
                   && (paddr[CFG_ADDR_W-2:0] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
    end else if (wr_hit) begin
      row_width_r <= pwdata[ROW_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ROW_WIDTH) begin
      prdata = CFG_DATA_W'(row_width_r);
    end
  end

  assign row_width = row_width_r;

endmodule
`default_nettype wire

// File: src/lfsf_tracker.sv
// Scoring stage: works out each cell's score from the buffered upper row,
// keeps the left/diagonal scores and the best cell, and registers the result.
// Depends on lfsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfsf_tracker #(
  parameter int MAX_COLS = lfsf_pkg::LFSF_MAX_COLS,
  parameter int MAX_ROWS = lfsf_pkg::LFSF_MAX_ROWS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  lfsf_pkg::lfsf_s1_t                   s1,
  input  wire  [$clog2(MAX_COLS)-1:0]          s1_col,
  input  wire  [$clog2(MAX_ROWS)-1:0]          s1_row,
  input  wire  [lfsf_pkg::SCORE_W-1:0]         up_score,
  output logic                                 go,
  output logic                                 wr_en,
  output logic [$clog2(MAX_COLS)-1:0]          wr_addr,
  output logic [lfsf_pkg::SCORE_W-1:0]         wr_data,
  input  wire                                  out_ready,
  output logic                                 out_valid,
  output logic [lfsf_pkg::SCORE_W-1:0]         out_size,
  output logic [lfsf_pkg::OUT_ROW_W-1:0]       out_row,
  output logic [lfsf_pkg::OUT_COL_W-1:0]       out_col
);
  import lfsf_pkg::*;

  localparam int ColW  = $clog2(MAX_COLS);
  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int ColXW = (ColW > OUT_COL_W) ? ColW : OUT_COL_W;
  localparam int RowXW = (RowW > OUT_ROW_W) ? RowW : OUT_ROW_W;

  logic [SCORE_W-1:0]   left_r, left_nxt;
  logic [SCORE_W-1:0]   diag_r, diag_nxt;
  logic [SCORE_W-1:0]   top_score_r, top_score_nxt;
  logic [RowW-1:0]      top_row_r, top_row_nxt;
  logic [ColW-1:0]      top_col_r, top_col_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]   out_size_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;

  logic [SCORE_W-1:0]   min_s;
  logic [SCORE_W-1:0]   score;
  logic                 better;
  logic [SCORE_W-1:0]   fin_size;
  logic [RowXW-1:0]     fin_row;
  logic [ColXW-1:0]     fin_col;

  always_comb begin
    min_s = diag_r;
    if (left_r < min_s) min_s = left_r;
    if (up_score < min_s) min_s = up_score;
    if (!s1.cell_open) begin
      score = '0;
    end else if ((s1_row == '0) || (s1_col == '0)) begin
      score = SCORE_W'(1);
    end else if (min_s == SCORE_MAX) begin
      score = SCORE_MAX;
    end else begin
      score = min_s + SCORE_W'(1);
    end
  end

  // Stall only while a finished result still waits at the output
  assign go      = s1.valid && !(s1.last_cell && out_valid_r && !out_ready);
  assign wr_en   = go;
  assign wr_addr = s1_col;
  assign wr_data = score;
  assign better  = score > top_score_r;

  always_comb begin
    fin_size = better ? score : top_score_r;
    fin_row  = better ? RowXW'(s1_row) : RowXW'(top_row_r);
    fin_col  = better ? ColXW'(s1_col) : ColXW'(top_col_r);
  end

  always_comb begin
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    top_score_nxt = top_score_r;
    top_row_nxt   = top_row_r;
    top_col_nxt   = top_col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (go) begin
      left_nxt = score;
      diag_nxt = up_score;
      if (s1.end_row || s1.last_cell) begin
        left_nxt = '0;
        diag_nxt = '0;
      end
      if (better) begin
        top_score_nxt = score;
        top_row_nxt   = s1_row;
        top_col_nxt   = s1_col;
      end
      if (s1.last_cell) begin
        top_score_nxt = '0;
        top_row_nxt   = '0;
        top_col_nxt   = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      top_score_r <= '0;
      top_row_r   <= '0;
      top_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      top_score_r <= top_score_nxt;
      top_row_r   <= top_row_nxt;
      top_col_r   <= top_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1.last_cell) begin
      out_size_r <= fin_size;
      out_row_r  <= fin_row[OUT_ROW_W-1:0];
      out_col_r  <= fin_col[OUT_COL_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_size  = out_size_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;

endmodule
`default_nettype wire

// File: src/largest_free_square_finder_core.sv
// Largest free square finder: top level with the raster scan counters.
// Depends on lfsf_pkg, lfsf_if, lfsf_row_mem, lfsf_cfg_regs, lfsf_tracker.
// Throughput: one cell item per cycle unless a last cell item stalls, set by the row buffer
//   read at accept and written back as the item leaves the scoring stage (same-entry reads are bypassed).
// Result: out_item.valid is raised from a register once the last cell item leaves the
//   scoring stage; a last cell item stalls there while the previous result item still waits.
// Reset (synchronous, rst_n low): scan, tracking and handshake state clear,
//   row_width returns to 1024; the row buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module largest_free_square_finder_core #(
  parameter int MAX_COLS = lfsf_pkg::LFSF_MAX_COLS,
  parameter int MAX_ROWS = lfsf_pkg::LFSF_MAX_ROWS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  lfsf_in_if.sink                          in_item,
  lfsf_out_if.source                       out_item,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lfsf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [lfsf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lfsf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lfsf_pkg::*;

  localparam int ColW = $clog2(MAX_COLS);
  localparam int RowW = $clog2(MAX_ROWS);
  localparam int CmpW = ((ColW + 1) > ROW_WIDTH_W) ? (ColW + 1) : ROW_WIDTH_W;

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CmpW-1:0]        width_raw;
  logic [CmpW-1:0]        width_eff;

  logic [ColW-1:0]        col_r, col_nxt;
  logic [RowW-1:0]        row_r, row_nxt;
  lfsf_s1_t               s1_r, s1_nxt;
  logic [ColW-1:0]        s1_col_r;
  logic [RowW-1:0]        s1_row_r;

  logic                   in_ready;
  logic                   accept;
  logic                   end_row;
  logic                   go;
  logic                   wr_en;
  logic [ColW-1:0]        wr_addr;
  logic [SCORE_W-1:0]     wr_data;
  logic [SCORE_W-1:0]     up_score;

  lfsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_width (row_width)
  );

  // Clamp the row width into 1..MAX_COLS
  always_comb begin
    width_raw = CmpW'(row_width);
    if (width_raw == '0) begin
      width_eff = CmpW'(1);
    end else if (width_raw > CmpW'(MAX_COLS)) begin
      width_eff = CmpW'(MAX_COLS);
    end else begin
      width_eff = width_raw;
    end
  end

  assign in_ready      = !s1_r.valid || go;
  assign in_item.ready = in_ready;
  assign accept        = in_item.valid && in_ready;
  assign end_row       = (CmpW'(col_r) + CmpW'(1)) >= width_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_row) begin
        col_nxt = '0;
        if (row_r < RowW'(MAX_ROWS - 1)) row_nxt = row_r + RowW'(1);
      end else begin
        col_nxt = col_r + ColW'(1);
      end
      if (in_item.last_cell) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (in_ready) begin
      s1_nxt.valid     = accept;
      s1_nxt.cell_open = in_item.cell_open;
      s1_nxt.last_cell = in_item.last_cell;
      s1_nxt.end_row   = end_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_r  <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  lfsf_row_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (up_score)
  );

  lfsf_tracker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1_r),
    .s1_col    (s1_col_r),
    .s1_row    (s1_row_r),
    .up_score  (up_score),
    .go        (go),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_ready (out_item.ready),
    .out_valid (out_item.valid),
    .out_size  (out_item.best_size),
    .out_row   (out_item.best_row),
    .out_col   (out_item.best_col)
  );

endmodule
`default_nettype wire
